// File: src/bcv_pkg.sv
// Shared types and constants for the bundle container validator.
// Phase encoding, status codes and header constants; no dependencies.
`default_nettype none

package bcv_pkg;

   localparam logic [31:0] MAGIC_WORD   = 32'h4241_5354;
   localparam logic [31:0] VERSION_WORD = 32'd1;

   typedef enum logic [7:0] {
      PH_MAGIC   = 8'b0000_0001,
      PH_VERSION = 8'b0000_0010,
      PH_COUNT   = 8'b0000_0100,
      PH_NAMELEN = 8'b0000_1000,
      PH_NAME    = 8'b0001_0000,
      PH_BLOBLEN = 8'b0010_0000,
      PH_BLOB    = 8'b0100_0000,
      PH_TAIL    = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SHORT_HDR   = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_TRUNCATED   = 3'd4,
      ST_BAD_NAME    = 3'd5,
      ST_BLOB_OVERRUN = 3'd6,
      ST_TRAILING    = 3'd7
   } status_type;

endpackage

`default_nettype wire

// File: src/bundle_container_validator_core.sv
// Byte-serial validator for a little-endian named-blob container.
// Depends on bcv_pkg for phase encoding, status codes and header constants.
//
//   channel | direction | ports                               | fires
//   req     | in        | req_data_in, req_final_byte         | every container byte
//   rsp     | out       | rsp_status, rsp_entries_seen        | once per final byte
//
// One byte per cycle: the byte updates the parse state in the cycle it is
// accepted, through one 32-bit decrement/compare stage.
// A final byte loads the result register as it is accepted and returns the
// parser to its header state, so a new container can start right behind it.
// req_ready drops only while a result is held and rsp_ready is low.
// Reset is synchronous and clears the parse state and rsp_valid.
`default_nettype none

module bundle_container_validator_core
   import bcv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_in,
   input  wire logic        req_final_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_entries_seen
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] entries_left_ff, entries_left_in;
   logic [31:0] entries_done_ff, entries_done_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   status_type  err_ff, err_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_entries_ff;

   logic        req_fire;
   logic [31:0] lane;
   logic [31:0] field_val;
   logic        field_last;
   logic [31:0] bytes_dec;
   logic [31:0] entries_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      lane        = {24'd0, req_data_in} << {idx_ff, 3'b000};
      field_val   = shift_ff | lane;
      field_last  = (phase_ff == PH_NAMELEN) ? (idx_ff == 2'd1) : (idx_ff == 2'd3);
      bytes_dec   = (bytes_left_ff != 32'd0) ? bytes_left_ff - 32'd1 : bytes_left_ff;
      entries_dec = entries_left_ff - 32'd1;

      phase_in        = phase_ff;
      idx_in          = idx_ff;
      shift_in        = shift_ff;
      entries_left_in = entries_left_ff;
      entries_done_in = entries_done_ff;
      bytes_left_in   = bytes_left_ff;
      err_in          = err_ff;

      unique case (phase_ff)
         PH_MAGIC, PH_VERSION, PH_COUNT, PH_NAMELEN, PH_BLOBLEN: begin
            if (field_last) begin
               idx_in   = 2'd0;
               shift_in = 32'd0;
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (field_val != MAGIC_WORD && err_ff == ST_OK) err_in = ST_BAD_MAGIC;
                     phase_in = PH_VERSION;
                  end
                  PH_VERSION: begin
                     if (field_val != VERSION_WORD && err_ff == ST_OK)
                        err_in = ST_BAD_VERSION;
                     phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     entries_left_in = field_val;
                     phase_in = (err_ff != ST_OK || field_val == 32'd0) ? PH_TAIL : PH_NAMELEN;
                  end
                  PH_NAMELEN: begin
                     if (field_val == 32'd0) begin
                        if (err_ff == ST_OK) err_in = ST_BAD_NAME;
                        phase_in = PH_TAIL;
                     end else begin
                        bytes_left_in = field_val;
                        phase_in = PH_NAME;
                     end
                  end
                  default: begin
                     if (field_val == 32'd0) begin
                        entries_done_in = entries_done_ff + 32'd1;
                        entries_left_in = entries_dec;
                        phase_in = (entries_dec == 32'd0) ? PH_TAIL : PH_NAMELEN;
                     end else begin
                        bytes_left_in = field_val;
                        phase_in = PH_BLOB;
                     end
                  end
               endcase
            end else begin
               idx_in   = idx_ff + 2'd1;
               shift_in = field_val;
            end
         end
         PH_NAME: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) phase_in = PH_BLOBLEN;
         end
         PH_BLOB: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               entries_done_in = entries_done_ff + 32'd1;
               entries_left_in = entries_dec;
               phase_in = (entries_dec == 32'd0) ? PH_TAIL : PH_NAMELEN;
            end
         end
         default: begin
            if (err_ff == ST_OK) err_in = ST_TRAILING;
         end
      endcase

      priority if (phase_in == PH_MAGIC || phase_in == PH_VERSION || phase_in == PH_COUNT)
         rsp_status_in = ST_SHORT_HDR;
      else if (err_in != ST_OK)
         rsp_status_in = err_in;
      else if (phase_in == PH_NAMELEN || phase_in == PH_BLOBLEN)
         rsp_status_in = ST_TRUNCATED;
      else if (phase_in == PH_NAME)
         rsp_status_in = ST_BAD_NAME;
      else if (phase_in == PH_BLOB)
         rsp_status_in = ST_BLOB_OVERRUN;
      else
         rsp_status_in = ST_OK;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (req_fire && req_final_byte) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_MAGIC;
         idx_ff          <= 2'd0;
         shift_ff        <= 32'd0;
         entries_left_ff <= 32'd0;
         entries_done_ff <= 32'd0;
         bytes_left_ff   <= 32'd0;
         err_ff          <= ST_OK;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            if (req_final_byte) begin
               phase_ff        <= PH_MAGIC;
               idx_ff          <= 2'd0;
               shift_ff        <= 32'd0;
               entries_left_ff <= 32'd0;
               entries_done_ff <= 32'd0;
               bytes_left_ff   <= 32'd0;
               err_ff          <= ST_OK;
            end else begin
               phase_ff        <= phase_in;
               idx_ff          <= idx_in;
               shift_ff        <= shift_in;
               entries_left_ff <= entries_left_in;
               entries_done_ff <= entries_done_in;
               bytes_left_ff   <= bytes_left_in;
               err_ff          <= err_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_final_byte) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_entries_ff <= entries_done_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entries_seen = rsp_entries_ff;

   a_final_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_byte |=> rsp_valid)
      else $error("final byte produced no result beat");

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_byte |=>
         phase_ff == PH_MAGIC && entries_done_ff == 32'd0 && err_ff == ST_OK)
      else $error("parser not back at header after final byte");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   a_body_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAME || phase_ff == PH_BLOB) |-> bytes_left_ff != 32'd0)
      else $error("name or blob phase with no bytes left");

endmodule

`default_nettype wire
